### rtl/core/ehp_pkg.sv
package ehp_pkg;

  localparam int unsigned COUNT_W = 15;

  localparam logic [COUNT_W-1:0] MAX_FRAME_BYTES = 15'd16384;

  // byte positions in the frame
  localparam logic [COUNT_W-1:0] POS_ETYPE_HI = 15'd12;
  localparam logic [COUNT_W-1:0] POS_ETYPE_LO = 15'd13;
  localparam logic [COUNT_W-1:0] POS_VER_IHL  = 15'd14;
  localparam logic [COUNT_W-1:0] POS_FIRST_L4 = 15'd15;
  localparam logic [COUNT_W-1:0] POS_PROTOCOL = 15'd23;
  localparam logic [COUNT_W-1:0] POS_SRC_FIRST = 15'd26;
  localparam logic [COUNT_W-1:0] POS_SRC_LAST  = 15'd29;
  localparam logic [COUNT_W-1:0] POS_DST_FIRST = 15'd30;
  localparam logic [COUNT_W-1:0] POS_DST_LAST  = 15'd33;
  localparam logic [COUNT_W-1:0] TCP_OFF_DELTA = 15'd12;

  localparam logic [7:0] ETH_HDR_BYTES = 8'd14;
  localparam logic [7:0] UDP_HDR_BYTES = 8'd8;
  localparam logic [3:0] IP_VERSION_4  = 4'd4;

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [15:0] ETHERTYPE_IPV6 = 16'h86dd;

  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] PROTO_TCP  = 8'd6;
  localparam logic [7:0] PROTO_UDP  = 8'd17;
  localparam logic [7:0] PROTO_GRE  = 8'd47;

  // fields_seen bit positions
  localparam int unsigned SEEN_ETYPE = 0;
  localparam int unsigned SEEN_VER   = 1;
  localparam int unsigned SEEN_ADDR  = 2;
  localparam int unsigned SEEN_TCP   = 3;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_IPV6     = 3'd1;
  localparam logic [2:0] ST_OTHER    = 3'd2;
  localparam logic [2:0] ST_VERSION  = 3'd3;
  localparam logic [2:0] ST_ZEROADDR = 3'd4;
  localparam logic [2:0] ST_BADL4    = 3'd5;
  localparam logic [2:0] ST_SHORT    = 3'd6;

  localparam logic [2:0] KIND_NONE = 3'd0;
  localparam logic [2:0] KIND_TCP  = 3'd1;
  localparam logic [2:0] KIND_UDP  = 3'd2;
  localparam logic [2:0] KIND_GRE  = 3'd3;
  localparam logic [2:0] KIND_ICMP = 3'd4;

  typedef struct packed {
    logic [15:0]        ethertype_word;
    logic [7:0]         version_and_ihl;
    logic [7:0]         protocol_number;
    logic               source_nonzero;
    logic               dest_nonzero;
    logic [7:0]         tcp_data_offset;
    logic [3:0]         fields_seen;
    logic [COUNT_W-1:0] frame_length;
  } ehp_summary_t;

  function automatic logic [7:0] l4_offset_of(input logic [7:0] ver_ihl);
    return ETH_HDR_BYTES + {2'b00, ver_ihl[3:0], 2'b00};
  endfunction

endpackage

### rtl/core/ehp_in_if.sv
interface ehp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

### rtl/core/ehp_out_if.sv
interface ehp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [2:0]  l4_kind;
  logic [7:0]  l4_offset;
  logic [7:0]  payload_offset;
  logic [14:0] frame_length;

  modport source (output valid, output status, output l4_kind, output l4_offset,
                  output payload_offset, output frame_length, input ready);
  modport sink (input valid, input status, input l4_kind, input l4_offset,
                input payload_offset, input frame_length, output ready);
endinterface

### rtl/core/ehp_field_capture.sv
module ehp_field_capture (
  input  logic                  clk,
  input  logic                  rst,
  ehp_in_if.sink                frame_in,
  output ehp_pkg::ehp_summary_t summary,
  output logic                  summary_valid,
  input  logic                  summary_ready
);
  import ehp_pkg::*;

  logic [COUNT_W-1:0] byte_count;
  logic [15:0]        ethertype_word;
  logic [7:0]         version_and_ihl;
  logic [7:0]         protocol_number;
  logic               source_nonzero;
  logic               dest_nonzero;
  logic [7:0]         tcp_data_offset;
  logic [3:0]         fields_seen;

  logic [COUNT_W-1:0] byte_count_next;
  logic [15:0]        ethertype_word_next;
  logic [7:0]         version_and_ihl_next;
  logic [7:0]         protocol_number_next;
  logic               source_nonzero_next;
  logic               dest_nonzero_next;
  logic [7:0]         tcp_data_offset_next;
  logic [3:0]         fields_seen_next;

  logic               accept;
  logic               counting;
  logic               byte_nonzero;
  logic [COUNT_W-1:0] tcp_pos;

  assign frame_in.ready = !summary_valid || summary_ready;
  assign accept         = frame_in.valid && frame_in.ready;
  assign counting       = byte_count < MAX_FRAME_BYTES;
  assign byte_nonzero   = frame_in.data_byte != 8'd0;
  assign tcp_pos        = {{(COUNT_W-8){1'b0}}, l4_offset_of(version_and_ihl)} + TCP_OFF_DELTA;

  always_comb begin
    byte_count_next      = byte_count;
    ethertype_word_next  = ethertype_word;
    version_and_ihl_next = version_and_ihl;
    protocol_number_next = protocol_number;
    source_nonzero_next  = source_nonzero;
    dest_nonzero_next    = dest_nonzero;
    tcp_data_offset_next = tcp_data_offset;
    fields_seen_next     = fields_seen;
    if (counting) begin
      byte_count_next = byte_count + 1'b1;
      if (byte_count == POS_ETYPE_HI) begin
        ethertype_word_next = {frame_in.data_byte, 8'h00};
      end
      if (byte_count == POS_ETYPE_LO) begin
        ethertype_word_next = {ethertype_word[15:8], frame_in.data_byte};
        fields_seen_next[SEEN_ETYPE] = 1'b1;
      end
      if (byte_count == POS_VER_IHL) begin
        version_and_ihl_next = frame_in.data_byte;
        fields_seen_next[SEEN_VER] = 1'b1;
      end
      if (byte_count == POS_PROTOCOL) begin
        protocol_number_next = frame_in.data_byte;
      end
      if (byte_count >= POS_SRC_FIRST && byte_count <= POS_SRC_LAST && byte_nonzero) begin
        source_nonzero_next = 1'b1;
      end
      if (byte_count >= POS_DST_FIRST && byte_count <= POS_DST_LAST && byte_nonzero) begin
        dest_nonzero_next = 1'b1;
      end
      if (byte_count == POS_DST_LAST) begin
        fields_seen_next[SEEN_ADDR] = 1'b1;
      end
      if (fields_seen[SEEN_VER] && byte_count >= POS_FIRST_L4 && byte_count == tcp_pos) begin
        tcp_data_offset_next = frame_in.data_byte;
        fields_seen_next[SEEN_TCP] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count      <= '0;
      ethertype_word  <= '0;
      version_and_ihl <= '0;
      protocol_number <= '0;
      source_nonzero  <= 1'b0;
      dest_nonzero    <= 1'b0;
      tcp_data_offset <= '0;
      fields_seen     <= '0;
      summary_valid   <= 1'b0;
    end else begin
      if (summary_valid && summary_ready) begin
        summary_valid <= 1'b0;
      end
      if (accept) begin
        if (frame_in.last_byte) begin
          // frame done: hand over and start the next one clean
          summary_valid   <= 1'b1;
          byte_count      <= '0;
          ethertype_word  <= '0;
          version_and_ihl <= '0;
          protocol_number <= '0;
          source_nonzero  <= 1'b0;
          dest_nonzero    <= 1'b0;
          tcp_data_offset <= '0;
          fields_seen     <= '0;
        end else begin
          byte_count      <= byte_count_next;
          ethertype_word  <= ethertype_word_next;
          version_and_ihl <= version_and_ihl_next;
          protocol_number <= protocol_number_next;
          source_nonzero  <= source_nonzero_next;
          dest_nonzero    <= dest_nonzero_next;
          tcp_data_offset <= tcp_data_offset_next;
          fields_seen     <= fields_seen_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && frame_in.last_byte) begin
      summary.ethertype_word  <= ethertype_word_next;
      summary.version_and_ihl <= version_and_ihl_next;
      summary.protocol_number <= protocol_number_next;
      summary.source_nonzero  <= source_nonzero_next;
      summary.dest_nonzero    <= dest_nonzero_next;
      summary.tcp_data_offset <= tcp_data_offset_next;
      summary.fields_seen     <= fields_seen_next;
      summary.frame_length    <= byte_count_next;
    end
  end

  a_count_cleared: assert property (@(posedge clk) disable iff (rst)
    accept && frame_in.last_byte |=> byte_count == '0 && fields_seen == '0)
    else $error("byte count not cleared after last word");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    byte_count <= MAX_FRAME_BYTES)
    else $error("byte count beyond maximum");

  a_summary_loaded: assert property (@(posedge clk) disable iff (rst)
    accept && frame_in.last_byte |=> summary_valid)
    else $error("frame summary lost");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    summary_valid && !summary_ready |-> !frame_in.ready)
    else $error("input taken while summary stalled");

endmodule

### rtl/core/ehp_classify.sv
module ehp_classify (
  input  logic                  clk,
  input  logic                  rst,
  input  ehp_pkg::ehp_summary_t summary,
  input  logic                  summary_valid,
  output logic                  summary_ready,
  ehp_out_if.source             result_out
);
  import ehp_pkg::*;

  logic [2:0]         status_next;
  logic [2:0]         kind_next;
  logic [7:0]         l4_next;
  logic [7:0]         l7_next;
  logic [7:0]         l4_calc;
  logic [7:0]         tcp_l7;
  logic [7:0]         udp_l7;
  logic [COUNT_W-1:0] len;

  assign summary_ready = !result_out.valid || result_out.ready;
  assign len           = summary.frame_length;
  assign l4_calc       = l4_offset_of(summary.version_and_ihl);
  assign tcp_l7        = l4_calc + {2'b00, summary.tcp_data_offset[7:4], 2'b00};
  assign udp_l7        = l4_calc + UDP_HDR_BYTES;

  always_comb begin
    status_next = ST_OK;
    kind_next   = KIND_NONE;
    l4_next     = '0;
    l7_next     = '0;
    if (!summary.fields_seen[SEEN_ETYPE]) begin
      status_next = ST_SHORT;
    end else if (summary.ethertype_word == ETHERTYPE_IPV6) begin
      status_next = ST_IPV6;
    end else if (summary.ethertype_word != ETHERTYPE_IPV4) begin
      status_next = ST_OTHER;
    end else if (!summary.fields_seen[SEEN_VER]) begin
      status_next = ST_SHORT;
    end else if (summary.version_and_ihl[7:4] != IP_VERSION_4) begin
      status_next = ST_VERSION;
    end else if (!summary.fields_seen[SEEN_ADDR]) begin
      status_next = ST_SHORT;
    end else if (!summary.source_nonzero || !summary.dest_nonzero) begin
      status_next = ST_ZEROADDR;
    end else begin
      l4_next = l4_calc;
      case (summary.protocol_number)
        PROTO_TCP: begin
          kind_next = KIND_TCP;
          if (!summary.fields_seen[SEEN_TCP]) begin
            status_next = ST_SHORT;
          end else begin
            l7_next = tcp_l7;
            if ({{(COUNT_W-8){1'b0}}, tcp_l7} > len) begin
              status_next = ST_SHORT;
            end
          end
        end
        PROTO_UDP: begin
          kind_next = KIND_UDP;
          l7_next   = udp_l7;
          if ({{(COUNT_W-8){1'b0}}, udp_l7} > len) begin
            status_next = ST_SHORT;
          end
        end
        PROTO_GRE: begin
          kind_next = KIND_GRE;
        end
        PROTO_ICMP: begin
          kind_next = KIND_ICMP;
        end
        default: begin
          status_next = ST_BADL4;
        end
      endcase
    end
    if (status_next != ST_OK) begin
      kind_next = KIND_NONE;
      l4_next   = '0;
      l7_next   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_out.valid <= 1'b0;
    end else if (summary_ready) begin
      result_out.valid <= summary_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (summary_ready && summary_valid) begin
      result_out.status         <= status_next;
      result_out.l4_kind        <= kind_next;
      result_out.l4_offset      <= l4_next;
      result_out.payload_offset <= l7_next;
      result_out.frame_length   <= len;
    end
  end

  a_error_clears: assert property (@(posedge clk) disable iff (rst)
    result_out.valid && result_out.status != ST_OK |->
      result_out.l4_kind == KIND_NONE && result_out.l4_offset == 8'd0 &&
      result_out.payload_offset == 8'd0)
    else $error("error result carries transport fields");

  a_ok_has_kind: assert property (@(posedge clk) disable iff (rst)
    result_out.valid && result_out.status == ST_OK |-> result_out.l4_kind != KIND_NONE)
    else $error("good result without transport kind");

  a_payload_in_frame: assert property (@(posedge clk) disable iff (rst)
    result_out.valid && result_out.status == ST_OK |->
      {7'd0, result_out.payload_offset} <= result_out.frame_length)
    else $error("payload offset beyond frame length");

  a_summary_taken: assert property (@(posedge clk) disable iff (rst)
    summary_valid && summary_ready |=> result_out.valid)
    else $error("summary dropped");

endmodule

### rtl/core/eth_ipv4_l4_header_parser.sv
// result path: last byte taken -> frame summary register -> result register
// throughput: one byte per cycle while frame_in.ready is high, set by the byte counter
// and capture compare
// a stalled result holds the summary register, and input stalls only when both are full
// reset: synchronous active-high rst clears the byte count, captured fields and valids
module eth_ipv4_l4_header_parser (
  input  logic      clk,
  input  logic      rst,
  ehp_in_if.sink    frame_in,
  ehp_out_if.source result_out
);
  import ehp_pkg::*;

  ehp_summary_t summary;
  logic         summary_valid;
  logic         summary_ready;

  ehp_field_capture u_capture (
    .clk           (clk),
    .rst           (rst),
    .frame_in      (frame_in),
    .summary       (summary),
    .summary_valid (summary_valid),
    .summary_ready (summary_ready)
  );

  ehp_classify u_classify (
    .clk           (clk),
    .rst           (rst),
    .summary       (summary),
    .summary_valid (summary_valid),
    .summary_ready (summary_ready),
    .result_out    (result_out)
  );

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
  import ehp_pkg::*;

  localparam logic [15:0] ETHERTYPE_ARP = 16'h0806;
  localparam int IDLE_LIMIT = 1000;
  localparam int RANDOM_BYTES = 160;

  typedef struct packed {
    logic [2:0]         status;
    logic [2:0]         l4_kind;
    logic [7:0]         l4_offset;
    logic [7:0]         payload_offset;
    logic [COUNT_W-1:0] frame_length;
  } frame_verdict_t;

  class header_verdict_board;
    logic [COUNT_W-1:0] byte_count;
    logic [15:0]        ethertype;
    logic [7:0]         ver_ihl;
    logic [7:0]         proto;
    logic               src_nz;
    logic               dst_nz;
    logic [7:0]         tcp_off;
    logic [3:0]         seen;
    frame_verdict_t     verdict_q[$];
    int                 errors;

    function new();
      errors = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      byte_count = '0;
      ethertype = '0;
      ver_ihl = '0;
      proto = '0;
      src_nz = 1'b0;
      dst_nz = 1'b0;
      tcp_off = '0;
      seen = '0;
    endfunction

    function int transport_start();
      return int'(ETH_HDR_BYTES) + 4 * int'(ver_ihl[3:0]);
    endfunction

    function int pending();
      return verdict_q.size();
    endfunction

    // works out the frame verdict once the final word of a frame is taken
    function void note_byte(logic [7:0] b, logic last);
      frame_verdict_t v;
      int pos;
      int l4;
      int l7;
      logic [2:0] st;
      logic [2:0] kind;
      if (byte_count < MAX_FRAME_BYTES) begin
        pos = int'(byte_count);
        if (pos == POS_ETYPE_HI) ethertype = {b, 8'h00};
        if (pos == POS_ETYPE_LO) begin
          ethertype[7:0] = b;
          seen[SEEN_ETYPE] = 1'b1;
        end
        if (pos == POS_VER_IHL) begin
          ver_ihl = b;
          seen[SEEN_VER] = 1'b1;
        end
        if (pos == POS_PROTOCOL) proto = b;
        if (pos >= POS_SRC_FIRST && pos <= POS_SRC_LAST && b != 8'h00) src_nz = 1'b1;
        if (pos >= POS_DST_FIRST && pos <= POS_DST_LAST && b != 8'h00) dst_nz = 1'b1;
        if (pos == POS_DST_LAST) seen[SEEN_ADDR] = 1'b1;
        if (seen[SEEN_VER] && pos >= POS_FIRST_L4 &&
            pos == transport_start() + int'(TCP_OFF_DELTA)) begin
          tcp_off = b;
          seen[SEEN_TCP] = 1'b1;
        end
        byte_count = byte_count + 1'b1;
      end
      if (!last) return;

      st = ST_OK;
      kind = KIND_NONE;
      l4 = 0;
      l7 = 0;
      if (!seen[SEEN_ETYPE]) st = ST_SHORT;
      else if (ethertype == ETHERTYPE_IPV6) st = ST_IPV6;
      else if (ethertype != ETHERTYPE_IPV4) st = ST_OTHER;
      else if (!seen[SEEN_VER]) st = ST_SHORT;
      else if (ver_ihl[7:4] != IP_VERSION_4) st = ST_VERSION;
      else if (!seen[SEEN_ADDR]) st = ST_SHORT;
      else if (!src_nz || !dst_nz) st = ST_ZEROADDR;
      else begin
        l4 = transport_start();
        case (proto)
          PROTO_TCP: begin
            kind = KIND_TCP;
            if (!seen[SEEN_TCP]) st = ST_SHORT;
            else begin
              l7 = l4 + 4 * int'(tcp_off[7:4]);
              if (l7 > int'(byte_count)) st = ST_SHORT;
            end
          end
          PROTO_UDP: begin
            kind = KIND_UDP;
            l7 = l4 + int'(UDP_HDR_BYTES);
            if (l7 > int'(byte_count)) st = ST_SHORT;
          end
          PROTO_GRE: kind = KIND_GRE;
          PROTO_ICMP: kind = KIND_ICMP;
          default: st = ST_BADL4;
        endcase
      end
      if (st != ST_OK) begin
        kind = KIND_NONE;
        l4 = 0;
        l7 = 0;
      end
      v.status = st;
      v.l4_kind = kind;
      v.l4_offset = l4[7:0];
      v.payload_offset = l7[7:0];
      v.frame_length = byte_count;
      verdict_q.push_back(v);
      clear_frame();
    endfunction

    function void field_check(string name, int want, int got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(frame_verdict_t got);
      frame_verdict_t want;
      if (verdict_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word, expected none, actual %p", $time, got);
        return;
      end
      want = verdict_q.pop_front();
      field_check("status", want.status, got.status);
      field_check("l4_kind", want.l4_kind, got.l4_kind);
      field_check("l4_offset", want.l4_offset, got.l4_offset);
      field_check("payload_offset", want.payload_offset, got.payload_offset);
      field_check("frame_length", want.frame_length, got.frame_length);
    endfunction
  endclass

  logic clk;
  logic rst;
  bit   quiet;
  int   idle_cycles;
  logic [7:0] frame_buf[$];
  header_verdict_board board = new();

  ehp_in_if  frame_if();
  ehp_out_if result_if();

  eth_ipv4_l4_header_parser dut (
    .clk(clk),
    .rst(rst),
    .frame_in(frame_if),
    .result_out(result_if)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic int draw_gap();
    return quiet ? 0 : $urandom_range(0, 15);
  endfunction

  function automatic void put_at(int pos, logic [7:0] val);
    if (pos < frame_buf.size()) frame_buf[pos] = val;
  endfunction

  function automatic void fill_frame(logic [15:0] etype, logic [7:0] ver_ihl,
                                     logic [7:0] proto, bit src_zero, bit dst_zero,
                                     logic [7:0] tcp_byte, int length, int pad);
    frame_buf.delete();
    for (int i = 0; i < length; i++) begin
      frame_buf.push_back(pad < 0 ? 8'($urandom) : 8'(pad));
    end
    put_at(POS_ETYPE_HI, etype[15:8]);
    put_at(POS_ETYPE_LO, etype[7:0]);
    put_at(POS_VER_IHL, ver_ihl);
    put_at(POS_PROTOCOL, proto);
    for (int i = POS_SRC_FIRST; i <= POS_DST_LAST; i++) begin
      put_at(i, ((i <= POS_SRC_LAST) ? src_zero : dst_zero) ? 8'h00 : 8'($urandom));
    end
    if (!src_zero) put_at(POS_SRC_LAST, 8'($urandom_range(1, 255)));
    if (!dst_zero) put_at(POS_DST_LAST, 8'($urandom_range(1, 255)));
    put_at(int'(ETH_HDR_BYTES) + 4 * int'(ver_ihl[3:0]) + int'(TCP_OFF_DELTA), tcp_byte);
  endfunction

  task automatic push_byte(logic [7:0] b, logic last);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      frame_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    frame_if.valid <= 1'b1;
    frame_if.data_byte <= b;
    frame_if.last_byte <= last;
    do @(posedge clk); while (!frame_if.ready);
    board.note_byte(b, last);
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_buf.size(); i++) begin
      push_byte(frame_buf[i], i == frame_buf.size() - 1);
    end
  endtask

  task automatic directed_frame(logic [15:0] etype, logic [7:0] ver_ihl, logic [7:0] proto,
                                bit src_zero, bit dst_zero, logic [7:0] tcp_byte,
                                int length, int pad);
    fill_frame(etype, ver_ihl, proto, src_zero, dst_zero, tcp_byte, length, pad);
    send_frame();
  endtask

  task automatic drain();
    frame_if.valid <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
  endtask

  // result side
  initial begin
    int stall;
    frame_verdict_t got;
    result_if.ready = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        result_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_if.ready <= 1'b1;
      do @(posedge clk); while (!result_if.valid);
      got.status = result_if.status;
      got.l4_kind = result_if.l4_kind;
      got.l4_offset = result_if.l4_offset;
      got.payload_offset = result_if.payload_offset;
      got.frame_length = result_if.frame_length;
      board.check_result(got);
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((frame_if.valid && frame_if.ready) || (result_if.valid && result_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int bytes_sent;
    int frames_sent;
    int pick;
    int l4;
    int length;
    logic [3:0] ihl;
    logic [7:0] ver_ihl;
    logic [7:0] proto;
    logic [15:0] etype;
    rst = 1'b1;
    quiet = 1'b0;
    frame_if.valid = 1'b0;
    frame_if.data_byte = '0;
    frame_if.last_byte = 1'b0;
    bytes_sent = 0;
    frames_sent = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // short frames and ethertype checks
    directed_frame(ETHERTYPE_IPV4, 8'h45, PROTO_TCP, 0, 0, 8'h50, 1, -1);
    directed_frame(ETHERTYPE_IPV4, 8'h45, PROTO_TCP, 0, 0, 8'h50, 13, -1);
    directed_frame(ETHERTYPE_IPV6, 8'h60, PROTO_TCP, 0, 0, 8'h50, 14, -1);
    directed_frame(ETHERTYPE_ARP, 8'h45, PROTO_UDP, 0, 0, 8'h50, 14, -1);
    directed_frame(ETHERTYPE_IPV4, 8'h45, PROTO_UDP, 0, 0, 8'h50, 14, -1);
    directed_frame(ETHERTYPE_IPV4, 8'h65, PROTO_UDP, 0, 0, 8'h50, 15, -1);
    directed_frame(ETHERTYPE_IPV4, 8'h45, PROTO_UDP, 0, 0, 8'h50, 24, -1);
    // address and protocol checks
    directed_frame(ETHERTYPE_IPV4, 8'h45, PROTO_UDP, 1, 0, 8'h50, 34, -1);
    directed_frame(ETHERTYPE_IPV4, 8'h45, PROTO_UDP, 0, 1, 8'h50, 34, -1);
    directed_frame(ETHERTYPE_IPV4, 8'h45, 8'hff, 0, 0, 8'h50, 34, -1);
    directed_frame(ETHERTYPE_IPV4, 8'h45, 8'h00, 0, 0, 8'h50, 34, -1);
    // tcp and udp payload against frame length
    directed_frame(ETHERTYPE_IPV4, 8'h45, PROTO_TCP, 0, 0, 8'h50, 54, -1);
    directed_frame(ETHERTYPE_IPV4, 8'h45, PROTO_TCP, 0, 0, 8'h50, 53, -1);
    directed_frame(ETHERTYPE_IPV4, 8'h45, PROTO_TCP, 0, 0, 8'h50, 40, -1);
    directed_frame(ETHERTYPE_IPV4, 8'h45, PROTO_UDP, 0, 0, 8'h50, 42, -1);
    directed_frame(ETHERTYPE_IPV4, 8'h45, PROTO_UDP, 0, 0, 8'h50, 41, -1);
    directed_frame(ETHERTYPE_IPV4, 8'h45, PROTO_GRE, 0, 0, 8'h50, 34, -1);
    directed_frame(ETHERTYPE_IPV4, 8'h45, PROTO_ICMP, 0, 0, 8'h50, 34, -1);
    // ihl and data offset extremes
    directed_frame(ETHERTYPE_IPV4, 8'h4f, PROTO_TCP, 0, 0, 8'hf0, 134, -1);
    directed_frame(ETHERTYPE_IPV4, 8'h40, PROTO_TCP, 0, 0, 8'h00, 34, -1);
    directed_frame(ETHERTYPE_IPV4, 8'h45, PROTO_TCP, 0, 0, 8'h0f, 47, -1);
    directed_frame(16'hffff, 8'hff, 8'hff, 0, 0, 8'hff, 14, 8'hff);
    directed_frame(16'h0000, 8'h00, 8'h00, 1, 1, 8'h00, 14, 8'h00);
    drain();

    while (bytes_sent < RANDOM_BYTES) begin
      quiet = ($urandom_range(0, 4) == 0);
      pick = $urandom_range(0, 99);
      ihl = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'd5;
      ver_ihl = ($urandom_range(0, 19) == 0) ? 8'($urandom) : {IP_VERSION_4, ihl};
      case ($urandom_range(0, 5))
        0, 1: proto = PROTO_TCP;
        2: proto = PROTO_UDP;
        3: proto = PROTO_GRE;
        4: proto = PROTO_ICMP;
        default: proto = 8'($urandom);
      endcase
      etype = ETHERTYPE_IPV4;
      if (pick >= 85) begin
        ver_ihl = 8'($urandom);
        case ($urandom_range(0, 3))
          0: etype = ETHERTYPE_IPV6;
          1: etype = ETHERTYPE_ARP;
          2: etype = 16'($urandom);
          default: etype = ETHERTYPE_IPV4;
        endcase
      end
      l4 = int'(ETH_HDR_BYTES) + 4 * int'(ver_ihl[3:0]);
      if (pick < 70) begin
        if ($urandom_range(0, 3) == 0) length = $urandom_range(34, l4 + 64);
        else length = ((l4 + 20 > 34) ? l4 + 20 : 34) + $urandom_range(0, 30);
      end else begin
        length = $urandom_range(1, 40);
      end
      fill_frame(etype, ver_ihl, proto, $urandom_range(0, 9) == 0, $urandom_range(0, 9) == 0,
                 8'($urandom), length, -1);
      send_frame();
      bytes_sent += length;
      frames_sent++;
      if (frames_sent % 8 == 0) drain();
    end
    quiet = 1'b0;
    drain();
    repeat (10) @(posedge clk);
    if (board.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
